FILE: rtl/core/srb_pkg.sv
// Shared types, constants and helpers for the sequenced ring buffer.
package srb_pkg;

  // Ring geometry
  localparam int SLOTS      = 16;
  localparam int SLOT_BYTES = 8;
  localparam int IDX_W      = $clog2(SLOTS);
  localparam int MAX_BATCH  = 64;

  // Field widths
  localparam int SEQ_W    = 32;
  localparam int DATA_W   = 64;
  localparam int LEN_W    = 8;
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;
  localparam int LIMIT_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;

  // Commands
  localparam logic [CMD_W-1:0] CMD_CLAIM   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PUBLISH = 2'd1;
  localparam logic [CMD_W-1:0] CMD_CONSUME = 2'd2;
  localparam logic [CMD_W-1:0] CMD_NOP     = 2'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd1;
  localparam logic [STATUS_W-1:0] ST_NOT_RUNNING = 3'd2;
  localparam logic [STATUS_W-1:0] ST_TOO_LONG    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ORDER       = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_RUNNING     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BATCH_LIMIT = 2'd1;

  typedef struct packed {
    logic               running;
    logic [LIMIT_W-1:0] batch_limit;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SEQ_W-1:0]    seq;
    logic [DATA_W-1:0]   data;
    logic                last;
  } res_t;

  // Mask covering the low n bytes of a data word (n at most 8)
  function automatic logic [DATA_W-1:0] byte_mask(input logic [3:0] n);
    logic [DATA_W-1:0] m;
    m = '0;
    for (int i = 0; i < DATA_W / 8; i++) begin
      m[i*8 +: 8] = (4'(i) < n) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  localparam logic [DATA_W-1:0] SLOT_MASK = byte_mask(4'(SLOT_BYTES));

endpackage

FILE: rtl/core/srb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module srb_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read; data holds while no read is issued
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

FILE: rtl/core/srb_ctrl.sv
// Command sequencer: sequence counters, slot read-modify-write and batch readout.
module srb_ctrl (
  input  logic                              clk,
  input  logic                              rst,
  input  srb_pkg::cfg_t                     cfg,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [srb_pkg::CMD_W-1:0]         cmd,
  input  logic [srb_pkg::SEQ_W-1:0]         seq,
  input  logic [srb_pkg::DATA_W-1:0]        data,
  input  logic [srb_pkg::LEN_W-1:0]         length,
  output logic                              res_valid,
  output srb_pkg::res_t                     res,
  input  logic                              res_ready
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_PUB  = 2'd1;
  localparam logic [1:0] S_CONS = 2'd2;

  logic [1:0] state, state_next;

  logic [srb_pkg::SEQ_W-1:0] claim_count, claim_count_next;
  logic [srb_pkg::SEQ_W-1:0] publish_count, publish_count_next;
  logic [srb_pkg::SEQ_W-1:0] consume_count, consume_count_next;

  // Pending publish and batch cursor
  logic [srb_pkg::SEQ_W-1:0]   pub_seq, pub_seq_next;
  logic [srb_pkg::DATA_W-1:0]  pub_data, pub_data_next;
  logic [srb_pkg::DATA_W-1:0]  pub_mask, pub_mask_next;
  logic [srb_pkg::SEQ_W-1:0]   cur, cur_next;
  logic [srb_pkg::LIMIT_W-1:0] remain, remain_next;

  // Memory port signals
  logic                        ram_we;
  logic [srb_pkg::IDX_W-1:0]   ram_waddr;
  logic [srb_pkg::DATA_W-1:0]  ram_wdata;
  logic                        ram_re;
  logic [srb_pkg::IDX_W-1:0]   ram_raddr;
  logic [srb_pkg::DATA_W-1:0]  ram_rdata;

  logic                        accept;
  logic [srb_pkg::SEQ_W-1:0]   avail;
  logic [srb_pkg::SEQ_W-1:0]   in_flight;
  logic [srb_pkg::SEQ_W-1:0]   first_seq;
  logic [srb_pkg::SEQ_W-1:0]   next_cur;
  logic [srb_pkg::LIMIT_W-1:0] lim;
  logic [srb_pkg::LIMIT_W-1:0] batch_n;

  srb_ram #(
    .WIDTH (srb_pkg::DATA_W),
    .DEPTH (srb_pkg::SLOTS)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Take a word only when idle and the result path can take a result
  assign in_stall = !((state == S_IDLE) && res_ready);
  assign accept   = in_valid && !in_stall;

  assign avail     = publish_count - consume_count;
  assign in_flight = claim_count - consume_count;
  assign first_seq = consume_count + 32'd1;
  assign next_cur  = cur + 32'd1;

  // Clamp batch limit to 1..MAX_BATCH, then size the batch
  always_comb begin
    lim = cfg.batch_limit;
    if (lim == '0) begin
      lim = srb_pkg::LIMIT_W'(1);
    end else if (lim > srb_pkg::LIMIT_W'(srb_pkg::MAX_BATCH)) begin
      lim = srb_pkg::LIMIT_W'(srb_pkg::MAX_BATCH);
    end
    if (avail < {{(srb_pkg::SEQ_W-srb_pkg::LIMIT_W){1'b0}}, lim}) begin
      batch_n = avail[srb_pkg::LIMIT_W-1:0];
    end else begin
      batch_n = lim;
    end
  end

  // Command decode and sequencing
  always_comb begin
    state_next         = state;
    claim_count_next   = claim_count;
    publish_count_next = publish_count;
    consume_count_next = consume_count;
    pub_seq_next       = pub_seq;
    pub_data_next      = pub_data;
    pub_mask_next      = pub_mask;
    cur_next           = cur;
    remain_next        = remain;
    res_valid          = 1'b0;
    res                = '0;
    res.last           = 1'b1;
    ram_we             = 1'b0;
    ram_waddr          = pub_seq[srb_pkg::IDX_W-1:0];
    ram_wdata          = (ram_rdata & ~pub_mask) | (pub_data & pub_mask);
    ram_re             = 1'b0;
    ram_raddr          = seq[srb_pkg::IDX_W-1:0];

    unique case (state)
      S_IDLE: begin
        if (accept && (cmd != srb_pkg::CMD_NOP)) begin
          if (!cfg.running) begin
            res_valid  = 1'b1;
            res.status = srb_pkg::ST_NOT_RUNNING;
          end else begin
            unique case (cmd)
              srb_pkg::CMD_CLAIM: begin
                res_valid = 1'b1;
                if (in_flight >= srb_pkg::SEQ_W'(srb_pkg::SLOTS)) begin
                  res.status = srb_pkg::ST_FULL;
                end else begin
                  claim_count_next = claim_count + 32'd1;
                  res.status       = srb_pkg::ST_OK;
                  res.seq          = claim_count + 32'd1;
                end
              end
              srb_pkg::CMD_PUBLISH: begin
                if (length > srb_pkg::LEN_W'(srb_pkg::SLOT_BYTES)) begin
                  res_valid  = 1'b1;
                  res.status = srb_pkg::ST_TOO_LONG;
                end else if ((seq != publish_count + 32'd1) ||
                             (publish_count == claim_count)) begin
                  res_valid  = 1'b1;
                  res.status = srb_pkg::ST_ORDER;
                end else begin
                  // Fetch old slot content for the partial merge
                  ram_re        = 1'b1;
                  ram_raddr     = seq[srb_pkg::IDX_W-1:0];
                  pub_seq_next  = seq;
                  pub_data_next = data;
                  pub_mask_next = srb_pkg::byte_mask(length[3:0]);
                  state_next    = S_PUB;
                end
              end
              srb_pkg::CMD_CONSUME: begin
                if (avail == '0) begin
                  res_valid  = 1'b1;
                  res.status = srb_pkg::ST_EMPTY;
                end else begin
                  ram_re      = 1'b1;
                  ram_raddr   = first_seq[srb_pkg::IDX_W-1:0];
                  cur_next    = first_seq;
                  remain_next = batch_n;
                  state_next  = S_CONS;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end

      S_PUB: begin
        // Merge new bytes over the old slot and write back
        if (res_ready) begin
          ram_we             = 1'b1;
          publish_count_next = pub_seq;
          res_valid          = 1'b1;
          res.status         = srb_pkg::ST_OK;
          state_next         = S_IDLE;
        end
      end

      S_CONS: begin
        // Emit one entry and prefetch the next while the batch lasts
        if (res_ready) begin
          res_valid  = 1'b1;
          res.status = srb_pkg::ST_OK;
          res.seq    = cur;
          res.data   = ram_rdata & srb_pkg::SLOT_MASK;
          res.last   = (remain == srb_pkg::LIMIT_W'(1));
          if (remain == srb_pkg::LIMIT_W'(1)) begin
            consume_count_next = cur;
            state_next         = S_IDLE;
          end else begin
            ram_re      = 1'b1;
            ram_raddr   = next_cur[srb_pkg::IDX_W-1:0];
            cur_next    = next_cur;
            remain_next = remain - srb_pkg::LIMIT_W'(1);
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      claim_count   <= '0;
      publish_count <= '0;
      consume_count <= '0;
      remain        <= '0;
    end else begin
      state         <= state_next;
      claim_count   <= claim_count_next;
      publish_count <= publish_count_next;
      consume_count <= consume_count_next;
      remain        <= remain_next;
    end
  end

  // Payload holding registers
  always_ff @(posedge clk) begin
    pub_seq  <= pub_seq_next;
    pub_data <= pub_data_next;
    pub_mask <= pub_mask_next;
    cur      <= cur_next;
  end

endmodule

FILE: rtl/core/sequenced_ring_buffer_batch.sv
// Sequenced ring buffer top: configuration registers and output register.
// Claim and rejected commands: result in the next cycle, one per cycle when not stalled.
// Publish: slot read, then merged write and result in S_PUB; next command waits until then.
// Consume: entries from the slot memory, the first via RAM and output registers, then
// one per cycle while out_stall is low; the next command is taken once the last word is out.
// Reset clears counters, running=0, batch_limit=1; slot memory is not cleared.
module sequenced_ring_buffer_batch (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [srb_pkg::CMD_W-1:0]         cmd,
  input  logic [srb_pkg::SEQ_W-1:0]         seq,
  input  logic [srb_pkg::DATA_W-1:0]        data,
  input  logic [srb_pkg::LEN_W-1:0]         length,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [srb_pkg::STATUS_W-1:0]      status,
  output logic [srb_pkg::SEQ_W-1:0]         out_seq,
  output logic [srb_pkg::DATA_W-1:0]        entry_data,
  output logic                              last,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [srb_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srb_pkg::CFG_DATA_W-1:0]    cfg_data
);

  srb_pkg::cfg_t cfg;
  srb_pkg::res_t res;
  srb_pkg::res_t out_word;
  logic          res_valid;
  logic          res_ready;

  assign cfg_ready = 1'b1;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.running     <= 1'b0;
      cfg.batch_limit <= srb_pkg::LIMIT_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        srb_pkg::CFG_RUNNING:     cfg.running     <= cfg_data[0];
        srb_pkg::CFG_BATCH_LIMIT: cfg.batch_limit <= cfg_data[srb_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  srb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cmd       (cmd),
    .seq       (seq),
    .data      (data),
    .length    (length),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_word <= res;
    end
  end

  assign status     = out_word.status;
  assign out_seq    = out_word.seq;
  assign entry_data = out_word.data;
  assign last       = out_word.last;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the sequenced ring buffer with batched consume.
`timescale 1ns / 1ps
module tb_top;
  import srb_pkg::*;

  // Tracks claim/publish/consume counters and slot contents; holds expected words
  class ring_tracker;
    logic [SEQ_W-1:0]   claim_cnt;
    logic [SEQ_W-1:0]   publish_cnt;
    logic [SEQ_W-1:0]   consume_cnt;
    logic [DATA_W-1:0]  slot_mem [SLOTS];
    bit                 slot_full [SLOTS];
    bit                 running;
    logic [LIMIT_W-1:0] batch_limit;
    res_t               pending_words [$];
    int                 errors;

    function new();
      claim_cnt   = '0;
      publish_cnt = '0;
      consume_cnt = '0;
      running     = 1'b0;
      batch_limit = LIMIT_W'(1);
      errors      = 0;
      foreach (slot_mem[i]) begin
        slot_mem[i]  = '0;
        slot_full[i] = 1'b0;
      end
    endfunction

    function void write_reg(input logic [CFG_IDX_W-1:0] idx,
                            input logic [CFG_DATA_W-1:0] val);
      if (idx == CFG_RUNNING) running = val[0];
      else if (idx == CFG_BATCH_LIMIT) batch_limit = LIMIT_W'(val);
    endfunction

    // Work out the words one accepted command produces and queue them
    function void accept_command(input logic [CMD_W-1:0] c, input logic [SEQ_W-1:0] s,
                                 input logic [DATA_W-1:0] d, input logic [LEN_W-1:0] len);
      res_t              w;
      logic [DATA_W-1:0] m;
      logic [SEQ_W-1:0]  used;
      logic [SEQ_W-1:0]  avail;
      logic [SEQ_W-1:0]  eseq;
      int                lim;
      int                n;
      if (c == CMD_NOP) return;
      w = '0;
      w.last = 1'b1;
      if (!running) begin
        w.status = ST_NOT_RUNNING;
        pending_words.push_back(w);
        return;
      end
      case (c)
        CMD_CLAIM: begin
          used = claim_cnt - consume_cnt;
          if (used >= SLOTS) begin
            w.status = ST_FULL;
          end else begin
            claim_cnt = claim_cnt + SEQ_W'(1);
            w.seq = claim_cnt;
          end
        end
        CMD_PUBLISH: begin
          if (len > SLOT_BYTES) begin
            w.status = ST_TOO_LONG;
          end else if (s != SEQ_W'(publish_cnt + SEQ_W'(1)) || publish_cnt == claim_cnt) begin
            w.status = ST_ORDER;
          end else begin
            // merge only the low len bytes, keep the rest of the slot
            m = '0;
            for (int b = 0; b < len; b++) m[b*8 +: 8] = 8'hFF;
            slot_mem[s[IDX_W-1:0]] = (slot_mem[s[IDX_W-1:0]] & ~m) | (d & m);
            if (len == SLOT_BYTES) slot_full[s[IDX_W-1:0]] = 1'b1;
            publish_cnt = s;
          end
        end
        default: begin
          avail = publish_cnt - consume_cnt;
          if (avail == 0) begin
            w.status = ST_EMPTY;
          end else begin
            // clamp the batch size, then hand out entries in order
            lim = batch_limit;
            if (lim < 1) lim = 1;
            if (lim > MAX_BATCH) lim = MAX_BATCH;
            n = (avail < SEQ_W'(lim)) ? int'(avail) : lim;
            for (int k = 0; k < n; k++) begin
              eseq   = consume_cnt + SEQ_W'(k + 1);
              w.seq  = eseq;
              w.data = slot_mem[eseq[IDX_W-1:0]] & SLOT_MASK;
              w.last = (k + 1 == n);
              pending_words.push_back(w);
            end
            consume_cnt = consume_cnt + SEQ_W'(n);
            return;
          end
        end
      endcase
      pending_words.push_back(w);
    endfunction

    // Compare one output word against the oldest expectation
    function void check_word(input logic [STATUS_W-1:0] st, input logic [SEQ_W-1:0] sq,
                             input logic [DATA_W-1:0] dt, input logic lst);
      res_t e;
      if (pending_words.size() == 0) begin
        $error("unexpected output word: status %0d out_seq %0d", st, sq);
        errors++;
        return;
      end
      e = pending_words.pop_front();
      if (st !== e.status) begin
        $error("status: expected %0d, actual %0d", e.status, st);
        errors++;
      end
      if (sq !== e.seq) begin
        $error("out_seq: expected %0d, actual %0d", e.seq, sq);
        errors++;
      end
      if (dt !== e.data) begin
        $error("entry_data: expected %0h, actual %0h", e.data, dt);
        errors++;
      end
      if (lst !== e.last) begin
        $error("last: expected %0d, actual %0d", e.last, lst);
        errors++;
      end
    endfunction
  endclass

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [CMD_W-1:0]      cmd = CMD_NOP;
  logic [SEQ_W-1:0]      seq = '0;
  logic [DATA_W-1:0]     data = '0;
  logic [LEN_W-1:0]      length = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [SEQ_W-1:0]      out_seq;
  logic [DATA_W-1:0]     entry_data;
  logic                  last;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_RUNNING;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  ring_tracker tracker;
  int          recv_pct = 0;
  int          hold_left = 0;
  int          claim_burst = 0;

  sequenced_ring_buffer_batch dut (.*);

  always #10 clk = ~clk;

  // Receiver: random stall, or a long hold-off while hold_left runs down
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_pct);
    end
  end

  // Check every output word taken by the receiver
  always @(posedge clk) begin
    if (!rst && out_valid === 1'b1 && out_stall === 1'b0)
      tracker.check_word(status, out_seq, entry_data, last);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    tracker.write_reg(idx, val);
  endtask

  // Write both registers; the running bit rides with random upper bits
  task automatic set_config(input bit run, input logic [LIMIT_W-1:0] limit);
    write_reg(CFG_RUNNING, {(CFG_DATA_W-1)'($urandom), run});
    write_reg(CFG_BATCH_LIMIT, CFG_DATA_W'(limit));
    cfg_valid <= 1'b0;
  endtask

  // Offer one command word and hold it until the block takes it
  task automatic issue(input logic [CMD_W-1:0] c, input logic [SEQ_W-1:0] s,
                       input logic [DATA_W-1:0] d, input logic [LEN_W-1:0] len);
    in_valid <= 1'b1;
    cmd      <= c;
    seq      <= s;
    data     <= d;
    length   <= len;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    tracker.accept_command(c, s, d, len);
  endtask

  // Drop valid, drain expected words, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (tracker.pending_words.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  // Mostly well-formed claim/publish/consume traffic, with some noise and bad publishes
  function automatic void pick_command(output logic [CMD_W-1:0] c,
                                       output logic [SEQ_W-1:0] s,
                                       output logic [DATA_W-1:0] d,
                                       output logic [LEN_W-1:0] len);
    int               roll;
    logic [SEQ_W-1:0] nxt;
    roll = $urandom_range(0, 99);
    nxt  = tracker.publish_cnt + SEQ_W'(1);
    c    = CMD_CLAIM;
    s    = nxt;
    d    = {$urandom, $urandom};
    len  = LEN_W'(SLOT_BYTES);
    if (claim_burst > 0) begin
      claim_burst--;
    end else if (roll < 4) begin
      c   = CMD_NOP;
      s   = $urandom;
      len = LEN_W'($urandom_range(0, 255));
    end else if (roll < 8) begin
      c = CMD_PUBLISH;
      if (roll[0]) s = $urandom;
      len = LEN_W'($urandom_range(SLOT_BYTES + 1, 255));
    end else if (roll < 12) begin
      c = CMD_PUBLISH;
      s = $urandom;
      if (s == nxt) s = nxt + SEQ_W'(1);
      len = LEN_W'($urandom_range(0, SLOT_BYTES));
    end else if (roll < 15) begin
      // run the ring into full
      claim_burst = 17;
    end else if (roll >= 78) begin
      c = CMD_CONSUME;
    end else if (roll >= 45) begin
      // short writes only once the slot holds a full word
      c = CMD_PUBLISH;
      if (tracker.slot_full[nxt[IDX_W-1:0]]) len = LEN_W'($urandom_range(0, SLOT_BYTES));
    end
  endfunction

  task automatic run_phase(input int n_items, input int gap_pct);
    int                done;
    logic [CMD_W-1:0]  c;
    logic [SEQ_W-1:0]  s;
    logic [DATA_W-1:0] d;
    logic [LEN_W-1:0]  len;
    done = 0;
    while (done < n_items) begin
      while ($urandom_range(0, 99) < gap_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
      pick_command(c, s, d, len);
      issue(c, s, d, len);
      if (c != CMD_NOP) done++;
    end
  endtask

  initial begin
    tracker = new();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Not running after reset: every command is refused, the NOP ignored
    issue(CMD_CLAIM, $urandom, {$urandom, $urandom}, LEN_W'(8));
    issue(CMD_PUBLISH, SEQ_W'(1), {$urandom, $urandom}, LEN_W'(8));
    issue(CMD_CONSUME, $urandom, {$urandom, $urandom}, LEN_W'(0));
    issue(CMD_NOP, $urandom, {$urandom, $urandom}, LEN_W'(8));
    settle();

    // Directed: empty, unclaimed, too long, out of order, batch limit zero
    set_config(1'b1, LIMIT_W'(0));
    issue(CMD_CONSUME, '0, '0, '0);
    issue(CMD_PUBLISH, SEQ_W'(1), '1, LEN_W'(8));
    issue(CMD_CLAIM, '1, '1, '1);
    issue(CMD_PUBLISH, SEQ_W'(1), '1, LEN_W'(SLOT_BYTES + 1));
    issue(CMD_PUBLISH, SEQ_W'(1), '1, LEN_W'(255));
    issue(CMD_PUBLISH, SEQ_W'(2), '1, LEN_W'(8));
    issue(CMD_PUBLISH, SEQ_W'(1), '1, LEN_W'(8));
    issue(CMD_CLAIM, '0, '0, '0);
    issue(CMD_PUBLISH, SEQ_W'(2), '0, LEN_W'(8));
    issue(CMD_CONSUME, '0, '0, '0);
    issue(CMD_CONSUME, '0, '0, '0);
    issue(CMD_CONSUME, '0, '0, '0);
    issue(CMD_NOP, '1, '1, '1);
    settle();

    // Sender idles lightly, receiver stalls heavily, limit above range
    set_config(1'b1, LIMIT_W'(127));
    recv_pct <= 57;
    run_phase(93, 17);
    settle();

    // Sender idles heavily, receiver stalls lightly, mid-range limit
    set_config(1'b1, LIMIT_W'($urandom_range(2, 63)));
    recv_pct <= 17;
    run_phase(93, 57);
    settle();

    // Stop the block with state held, then resume
    set_config(1'b0, LIMIT_W'(MAX_BATCH));
    issue(CMD_CLAIM, '0, '0, '0);
    issue(CMD_CONSUME, '0, '0, '0);
    settle();

    // No idling; hold the receiver off so the block backs up
    set_config(1'b1, LIMIT_W'(MAX_BATCH));
    recv_pct  <= 0;
    hold_left <= 300;
    run_phase(94, 0);
    settle();

    if (tracker.errors == 0 && tracker.pending_words.size() == 0) begin
      $display("sequenced_ring_buffer_batch verification clean");
    end else begin
      $display("sequenced_ring_buffer_batch verification failed");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(20_000_000);
    $display("sequenced_ring_buffer_batch verification failed");
    $finish;
  end

endmodule
